@@ rtl/core/mpcm_pkg.sv @@
// Shared types, codes and constants of the multi-pattern cover matcher.
`timescale 1ns / 1ps
package mpcm_pkg;

	localparam int ALPHABET = 26;
	localparam int OP_W     = 2;
	localparam int SYM_W    = 5;
	localparam int MATCH_W  = 7;
	localparam int COUNT_W  = 21;
	localparam int STATUS_W = 2;
	localparam int MAX_TEXT = 1048576;

	// operation codes
	localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
	localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
	localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [MATCH_W-1:0]  match_length;
		logic [COUNT_W-1:0]  uncovered_count;
		logic                count_valid;
		logic [STATUS_W-1:0] status;
	} result_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_TAIL,
		S_MARK,
		S_SCAN_NEXT,
		S_SCAN_UPD,
		S_POP,
		S_SCAN_END,
		S_BLD_ROOT,
		S_BLD_C,
		S_BLD_U,
		S_BLD_FU,
		S_BLD_WROW,
		S_BLD_POP,
		S_BLD_NOW,
		S_BLD_F,
		S_BLD_FROW,
		S_FINISH
	} ctrl_state_t;

	typedef enum logic [5:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_CAPTURE,
		CMD_SET_BAD,
		CMD_SET_ERR1,
		CMD_SET_ERR2,
		CMD_RD_CUR,
		CMD_ADVANCE,
		CMD_CREATE,
		CMD_RD_MARK,
		CMD_MARK,
		CMD_PAT_DONE,
		CMD_RD_SCAN,
		CMD_SCAN_ROOT,
		CMD_SCAN_STEP,
		CMD_SCAN_UPD,
		CMD_POP_STEP,
		CMD_SCAN_END,
		CMD_BLD_INIT,
		CMD_LATCH_ROW,
		CMD_FILL,
		CMD_RD_U,
		CMD_LATCH_U,
		CMD_WR_U,
		CMD_ROW_WR,
		CMD_Q_RD,
		CMD_NOW_RD,
		CMD_F_RD,
		CMD_LATCH_F,
		CMD_BLD_DONE,
		CMD_EMIT
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            scan_phase;
		logic            perr_set;
		logic            ins_bad;
		logic            sym_bad;
		logic            last;
		logic            ins_child_zero;
		logic            trie_full;
		logic            bld_child_zero;
		logic            c_last;
		logic            q_empty;
		logic            clr_last;
		logic            pop_last;
		logic            out_busy;
	} dp_status_t;

endpackage

@@ rtl/core/mpcm_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/mpcm_datapath.sv @@
// Datapath: trie memories, BFS queue, scan window and result register.
`timescale 1ns / 1ps
module mpcm_datapath #(
	parameter int MAX_NODES   = 4096,
	parameter int MAX_PATTERN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpcm_pkg::dp_cmd_t    cmd,
	input  mpcm_pkg::item_t      item,
	input  logic                 result_stall,
	output mpcm_pkg::dp_status_t st,
	output logic                 result_valid,
	output mpcm_pkg::result_t    result
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int AL    = mpcm_pkg::ALPHABET;
	localparam int ROW_W = AL * NW;
	localparam int M_W   = mpcm_pkg::MATCH_W;
	localparam int C_W   = mpcm_pkg::COUNT_W;
	localparam int S_W   = mpcm_pkg::SYM_W;
	localparam int REC_W = 1 + 2 * M_W + NW;
	localparam int PL_W  = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	typedef logic [AL-1:0][NW-1:0] row_t;

	// node record: {terminal, depth, longest, fail}
	function automatic logic [REC_W-1:0] mk_rec(input logic term, input logic [M_W-1:0] dep,
			input logic [M_W-1:0] lng, input logic [NW-1:0] fl);
		return {term, dep, lng, fl};
	endfunction

	function automatic logic [C_W-1:0] sat_inc(input logic [C_W-1:0] v);
		return (v >= C_W'(mpcm_pkg::MAX_TEXT)) ? v : v + 1'b1;
	endfunction

	// item and result
	logic [mpcm_pkg::OP_W-1:0] op_q;
	logic [S_W-1:0]            sym_q;
	logic                      last_q;
	mpcm_pkg::result_t         res_q;
	mpcm_pkg::result_t         out_q;
	logic                      out_valid_q;

	// load / scan state
	logic                              phase_q;
	logic [NW-1:0]                     cursor_q;
	logic [PL_W-1:0]                   plen_q;
	logic [mpcm_pkg::STATUS_W-1:0]     perr_q;
	logic [NW-1:0]                     ncount_q;
	logic [NW-1:0]                     scan_node_q;
	logic [MAX_PATTERN-1:0]            win_q;
	logic [PL_W-1:0]                   fill_q;
	logic [C_W-1:0]                    unc_q;
	logic [IDX_W-1:0]                  idx_q;
	logic [NW-1:0]                     clr_q;

	// build state
	logic [NW-1:0]    head_q;
	logic [NW-1:0]    tail_q;
	logic [NW-1:0]    now_q;
	logic [S_W-1:0]   c_q;
	row_t             now_row_q;
	row_t             f_row_q;
	logic [NW-1:0]    u_q;
	logic [NW-1:0]    fu_q;
	logic [REC_W-1:0] urec_q;

	// memory ports
	logic             g_we, g_re, n_we, n_re, q_we, q_re;
	logic [NW-1:0]    g_waddr, g_raddr, n_waddr, n_raddr, q_waddr, q_raddr;
	logic [ROW_W-1:0] g_wdata, g_rdata;
	logic [REC_W-1:0] n_wdata, n_rdata;
	logic [NW-1:0]    q_wdata, q_rdata;

	row_t             g_row;
	row_t             ins_row;
	logic [NW-1:0]    new_node;
	logic [M_W-1:0]   n_longest, n_depth, own, best, match;
	logic [NW-1:0]    n_fail;
	logic [MAX_PATTERN-1:0] mask;

	assign g_row     = row_t'(g_rdata);
	assign n_fail    = n_rdata[NW-1:0];
	assign n_longest = n_rdata[NW +: M_W];
	assign n_depth   = n_rdata[NW + M_W +: M_W];
	assign new_node  = ncount_q + 1'b1;
	assign own       = urec_q[REC_W-1] ? urec_q[NW + M_W +: M_W] : '0;
	assign best      = (own > n_longest) ? own : n_longest;
	assign match     = (n_longest > M_W'(MAX_PATTERN)) ? M_W'(MAX_PATTERN) : n_longest;

	always_comb begin
		ins_row = g_row;
		ins_row[sym_q] = new_node;
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			mask[i] = (M_W'(i) < match);
		end
	end

	always_comb begin
		g_we = 1'b0; g_re = 1'b0; n_we = 1'b0; n_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
		g_waddr = cursor_q; g_raddr = cursor_q; g_wdata = '0;
		n_waddr = cursor_q; n_raddr = cursor_q; n_wdata = '0;
		q_waddr = tail_q; q_raddr = head_q; q_wdata = u_q;
		unique case (cmd)
			mpcm_pkg::CMD_CLEAR: begin
				g_we = 1'b1; g_waddr = clr_q;
				n_we = 1'b1; n_waddr = clr_q;
			end
			mpcm_pkg::CMD_RD_CUR: begin
				g_re = 1'b1; n_re = 1'b1;
			end
			mpcm_pkg::CMD_CREATE: begin
				g_we = 1'b1; g_wdata = ROW_W'(ins_row);
				n_we = 1'b1; n_waddr = new_node;
				n_wdata = mk_rec(1'b0, n_depth + 1'b1, '0, '0);
			end
			mpcm_pkg::CMD_RD_MARK: n_re = 1'b1;
			mpcm_pkg::CMD_MARK: begin
				n_we = 1'b1; n_wdata = mk_rec(1'b1, n_depth, n_longest, n_fail);
			end
			mpcm_pkg::CMD_RD_SCAN: begin
				g_re = 1'b1; g_raddr = scan_node_q;
			end
			mpcm_pkg::CMD_SCAN_ROOT: begin
				n_re = 1'b1; n_raddr = '0;
			end
			mpcm_pkg::CMD_SCAN_STEP: begin
				n_re = 1'b1; n_raddr = g_row[sym_q];
			end
			mpcm_pkg::CMD_BLD_INIT: begin
				g_re = 1'b1; g_raddr = '0;
			end
			mpcm_pkg::CMD_RD_U: begin
				n_re = 1'b1; n_raddr = now_row_q[c_q];
			end
			mpcm_pkg::CMD_LATCH_U: begin
				n_re = 1'b1; n_raddr = fu_q;
			end
			mpcm_pkg::CMD_WR_U: begin
				n_we = 1'b1; n_waddr = u_q;
				n_wdata = mk_rec(urec_q[REC_W-1], urec_q[NW + M_W +: M_W], best, fu_q);
				q_we = 1'b1;
			end
			mpcm_pkg::CMD_ROW_WR: begin
				g_we = 1'b1; g_waddr = now_q; g_wdata = ROW_W'(now_row_q);
			end
			mpcm_pkg::CMD_Q_RD: q_re = 1'b1;
			mpcm_pkg::CMD_NOW_RD: begin
				n_re = 1'b1; n_raddr = q_rdata;
				g_re = 1'b1; g_raddr = q_rdata;
			end
			mpcm_pkg::CMD_F_RD: begin
				g_re = 1'b1; g_raddr = n_fail;
			end
			default: ;
		endcase
	end

	mpcm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_goto_ram (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata)
	);

	mpcm_ram #(.WIDTH(REC_W), .DEPTH(MAX_NODES)) u_node_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rdata)
	);

	mpcm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.re(q_re), .raddr(q_raddr), .rdata(q_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			cursor_q    <= '0;
			plen_q      <= '0;
			perr_q      <= mpcm_pkg::ST_OK;
			ncount_q    <= '0;
			scan_node_q <= '0;
			win_q       <= '0;
			fill_q      <= '0;
			unc_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word refills the slot in the cycle the old one drains
			if (cmd == mpcm_pkg::CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd)
				mpcm_pkg::CMD_CLEAR: clr_q <= clr_q + 1'b1;
				mpcm_pkg::CMD_SET_ERR1: perr_q <= mpcm_pkg::ST_FULL;
				mpcm_pkg::CMD_SET_ERR2: perr_q <= mpcm_pkg::ST_BAD;
				mpcm_pkg::CMD_ADVANCE: begin
					cursor_q <= g_row[sym_q];
					plen_q   <= plen_q + 1'b1;
				end
				mpcm_pkg::CMD_CREATE: begin
					cursor_q <= new_node;
					ncount_q <= new_node;
					plen_q   <= plen_q + 1'b1;
				end
				mpcm_pkg::CMD_MARK, mpcm_pkg::CMD_PAT_DONE: begin
					if (last_q) begin
						cursor_q <= '0;
						plen_q   <= '0;
						perr_q   <= mpcm_pkg::ST_OK;
					end
				end
				mpcm_pkg::CMD_SCAN_ROOT: scan_node_q <= '0;
				mpcm_pkg::CMD_SCAN_STEP: scan_node_q <= g_row[sym_q];
				mpcm_pkg::CMD_SCAN_UPD: begin
					if (fill_q >= PL_W'(MAX_PATTERN)) begin
						if (!win_q[MAX_PATTERN-1]) begin
							unc_q <= sat_inc(unc_q);
						end
					end else begin
						fill_q <= fill_q + 1'b1;
					end
					win_q <= (win_q << 1) | mask;
				end
				mpcm_pkg::CMD_POP_STEP: begin
					if ((PL_W'(idx_q) < fill_q) && !win_q[0]) begin
						unc_q <= sat_inc(unc_q);
					end
					win_q <= win_q >> 1;
				end
				mpcm_pkg::CMD_SCAN_END: begin
					scan_node_q <= '0;
					win_q       <= '0;
					fill_q      <= '0;
					unc_q       <= '0;
				end
				mpcm_pkg::CMD_BLD_INIT: begin
					head_q <= '0;
					tail_q <= '0;
				end
				mpcm_pkg::CMD_WR_U: tail_q <= tail_q + 1'b1;
				mpcm_pkg::CMD_Q_RD: head_q <= head_q + 1'b1;
				mpcm_pkg::CMD_BLD_DONE: begin
					phase_q     <= 1'b1;
					cursor_q    <= '0;
					plen_q      <= '0;
					perr_q      <= mpcm_pkg::ST_OK;
					scan_node_q <= '0;
					win_q       <= '0;
					fill_q      <= '0;
					unc_q       <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			mpcm_pkg::CMD_CAPTURE: begin
				op_q   <= item.operation;
				sym_q  <= item.symbol;
				last_q <= item.last;
				res_q  <= '0;
			end
			mpcm_pkg::CMD_SET_BAD: res_q.status <= mpcm_pkg::ST_BAD;
			mpcm_pkg::CMD_MARK, mpcm_pkg::CMD_PAT_DONE: res_q.status <= perr_q;
			mpcm_pkg::CMD_SCAN_UPD: begin
				res_q.match_length <= match;
				idx_q <= '0;
			end
			mpcm_pkg::CMD_POP_STEP: idx_q <= idx_q + 1'b1;
			mpcm_pkg::CMD_SCAN_END: begin
				res_q.uncovered_count <= unc_q;
				res_q.count_valid     <= 1'b1;
			end
			mpcm_pkg::CMD_BLD_INIT: begin
				now_q   <= '0;
				f_row_q <= '0;
				c_q     <= '0;
			end
			mpcm_pkg::CMD_LATCH_ROW, mpcm_pkg::CMD_F_RD: begin
				now_row_q <= g_row;
				c_q       <= '0;
			end
			mpcm_pkg::CMD_FILL: begin
				now_row_q[c_q] <= f_row_q[c_q];
				c_q <= c_q + 1'b1;
			end
			mpcm_pkg::CMD_RD_U: begin
				u_q  <= now_row_q[c_q];
				fu_q <= f_row_q[c_q];
			end
			mpcm_pkg::CMD_LATCH_U: urec_q <= n_rdata;
			mpcm_pkg::CMD_WR_U: c_q <= c_q + 1'b1;
			mpcm_pkg::CMD_NOW_RD: now_q <= q_rdata;
			mpcm_pkg::CMD_LATCH_F: f_row_q <= g_row;
			mpcm_pkg::CMD_EMIT: out_q <= res_q;
			default: ;
		endcase
	end

	always_comb begin
		st.op             = op_q;
		st.scan_phase     = phase_q;
		st.perr_set       = (perr_q != mpcm_pkg::ST_OK);
		st.sym_bad        = (sym_q >= S_W'(AL));
		st.ins_bad        = (plen_q >= PL_W'(MAX_PATTERN)) || st.sym_bad;
		st.last           = last_q;
		st.ins_child_zero = (g_row[sym_q] == '0);
		st.trie_full      = (ncount_q >= NW'(MAX_NODES - 1));
		st.bld_child_zero = (now_row_q[c_q] == '0);
		st.c_last         = (c_q == S_W'(AL - 1));
		st.q_empty        = (head_q == tail_q);
		st.clr_last       = (clr_q == NW'(MAX_NODES - 1));
		st.pop_last       = (idx_q == IDX_W'(MAX_PATTERN - 1));
		st.out_busy       = out_valid_q && result_stall;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ rtl/core/mpcm_ctrl.sv @@
// Controller: sequences the datapath one command per cycle.
`timescale 1ns / 1ps
module mpcm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  mpcm_pkg::dp_status_t st,
	output logic                 item_stall,
	output mpcm_pkg::dp_cmd_t    cmd
);

	mpcm_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpcm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != mpcm_pkg::S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpcm_pkg::S_CLEAR: if (st.clr_last) state_d = mpcm_pkg::S_IDLE;
			mpcm_pkg::S_IDLE: if (item_valid) state_d = mpcm_pkg::S_DECODE;
			mpcm_pkg::S_DECODE: begin
				priority if (st.op == mpcm_pkg::OP_PATTERN && !st.scan_phase) begin
					state_d = (st.perr_set || st.ins_bad) ? mpcm_pkg::S_TAIL
					                                      : mpcm_pkg::S_INS_CHK;
				end else if (st.op == mpcm_pkg::OP_BUILD && !st.scan_phase) begin
					state_d = mpcm_pkg::S_BLD_ROOT;
				end else if (st.op == mpcm_pkg::OP_TEXT && st.scan_phase) begin
					state_d = st.sym_bad ? mpcm_pkg::S_SCAN_UPD : mpcm_pkg::S_SCAN_NEXT;
				end else begin
					state_d = mpcm_pkg::S_FINISH;
				end
			end
			mpcm_pkg::S_INS_CHK: state_d = mpcm_pkg::S_TAIL;
			mpcm_pkg::S_TAIL:
				state_d = (st.last && !st.perr_set) ? mpcm_pkg::S_MARK : mpcm_pkg::S_FINISH;
			mpcm_pkg::S_MARK: state_d = mpcm_pkg::S_FINISH;
			mpcm_pkg::S_SCAN_NEXT: state_d = mpcm_pkg::S_SCAN_UPD;
			mpcm_pkg::S_SCAN_UPD: state_d = st.last ? mpcm_pkg::S_POP : mpcm_pkg::S_FINISH;
			mpcm_pkg::S_POP: if (st.pop_last) state_d = mpcm_pkg::S_SCAN_END;
			mpcm_pkg::S_SCAN_END: state_d = mpcm_pkg::S_FINISH;
			mpcm_pkg::S_BLD_ROOT: state_d = mpcm_pkg::S_BLD_C;
			mpcm_pkg::S_BLD_C: begin
				if (!st.bld_child_zero) begin
					state_d = mpcm_pkg::S_BLD_U;
				end else if (st.c_last) begin
					state_d = mpcm_pkg::S_BLD_WROW;
				end
			end
			mpcm_pkg::S_BLD_U: state_d = mpcm_pkg::S_BLD_FU;
			mpcm_pkg::S_BLD_FU: state_d = st.c_last ? mpcm_pkg::S_BLD_WROW : mpcm_pkg::S_BLD_C;
			mpcm_pkg::S_BLD_WROW: state_d = mpcm_pkg::S_BLD_POP;
			mpcm_pkg::S_BLD_POP: state_d = st.q_empty ? mpcm_pkg::S_FINISH : mpcm_pkg::S_BLD_NOW;
			mpcm_pkg::S_BLD_NOW: state_d = mpcm_pkg::S_BLD_F;
			mpcm_pkg::S_BLD_F: state_d = mpcm_pkg::S_BLD_FROW;
			mpcm_pkg::S_BLD_FROW: state_d = mpcm_pkg::S_BLD_C;
			mpcm_pkg::S_FINISH: if (!st.out_busy) state_d = mpcm_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = mpcm_pkg::CMD_NONE;
		unique case (state_q)
			mpcm_pkg::S_CLEAR: cmd = mpcm_pkg::CMD_CLEAR;
			mpcm_pkg::S_IDLE: if (item_valid) cmd = mpcm_pkg::CMD_CAPTURE;
			mpcm_pkg::S_DECODE: begin
				priority if (st.op == mpcm_pkg::OP_PATTERN && !st.scan_phase) begin
					priority if (st.perr_set) cmd = mpcm_pkg::CMD_NONE;
					else if (st.ins_bad) cmd = mpcm_pkg::CMD_SET_ERR2;
					else cmd = mpcm_pkg::CMD_RD_CUR;
				end else if (st.op == mpcm_pkg::OP_BUILD && !st.scan_phase) begin
					cmd = mpcm_pkg::CMD_BLD_INIT;
				end else if (st.op == mpcm_pkg::OP_TEXT && st.scan_phase) begin
					cmd = st.sym_bad ? mpcm_pkg::CMD_SCAN_ROOT : mpcm_pkg::CMD_RD_SCAN;
				end else begin
					cmd = mpcm_pkg::CMD_SET_BAD;
				end
			end
			mpcm_pkg::S_INS_CHK: begin
				priority if (!st.ins_child_zero) cmd = mpcm_pkg::CMD_ADVANCE;
				else if (st.trie_full) cmd = mpcm_pkg::CMD_SET_ERR1;
				else cmd = mpcm_pkg::CMD_CREATE;
			end
			mpcm_pkg::S_TAIL:
				cmd = (st.last && !st.perr_set) ? mpcm_pkg::CMD_RD_MARK : mpcm_pkg::CMD_PAT_DONE;
			mpcm_pkg::S_MARK: cmd = mpcm_pkg::CMD_MARK;
			mpcm_pkg::S_SCAN_NEXT: cmd = mpcm_pkg::CMD_SCAN_STEP;
			mpcm_pkg::S_SCAN_UPD: cmd = mpcm_pkg::CMD_SCAN_UPD;
			mpcm_pkg::S_POP: cmd = mpcm_pkg::CMD_POP_STEP;
			mpcm_pkg::S_SCAN_END: cmd = mpcm_pkg::CMD_SCAN_END;
			mpcm_pkg::S_BLD_ROOT: cmd = mpcm_pkg::CMD_LATCH_ROW;
			mpcm_pkg::S_BLD_C: cmd = st.bld_child_zero ? mpcm_pkg::CMD_FILL : mpcm_pkg::CMD_RD_U;
			mpcm_pkg::S_BLD_U: cmd = mpcm_pkg::CMD_LATCH_U;
			mpcm_pkg::S_BLD_FU: cmd = mpcm_pkg::CMD_WR_U;
			mpcm_pkg::S_BLD_WROW: cmd = mpcm_pkg::CMD_ROW_WR;
			mpcm_pkg::S_BLD_POP: cmd = st.q_empty ? mpcm_pkg::CMD_BLD_DONE : mpcm_pkg::CMD_Q_RD;
			mpcm_pkg::S_BLD_NOW: cmd = mpcm_pkg::CMD_NOW_RD;
			mpcm_pkg::S_BLD_F: cmd = mpcm_pkg::CMD_F_RD;
			mpcm_pkg::S_BLD_FROW: cmd = mpcm_pkg::CMD_LATCH_F;
			mpcm_pkg::S_FINISH: if (!st.out_busy) cmd = mpcm_pkg::CMD_EMIT;
		endcase
	end

endmodule

@@ rtl/core/multi_pattern_cover_matcher_core.sv @@
// Top level of the multi-pattern cover matcher: controller plus datapath.
`timescale 1ns / 1ps
// Aho-Corasick style matcher with coverage count. Pattern words (operation 0) build a
// trie one letter per word; a build word (operation 1) computes failure links, full goto
// rows and the longest pattern ending at every node, then the block enters the scan
// phase for good. Text words (operation 2) advance the automaton and return the longest
// match ending there; the word with last set also returns the number of text positions
// no match covers and clears the scan state for the next text. Exactly one result word
// per item word. After reset the block runs a clearing pass over every row of the goto-row
// and node memories, one row per cycle, with item_stall high. One item is in work at a
// time; the goto-row RAM and node RAM are single read port memories and set the pace: a
// text word reads its goto row, then its node record, and on the last word the coverage
// count walks the window one bit per cycle. The build word visits every node, every goto
// entry and every child edge in turn.
module multi_pattern_cover_matcher_core #(
	parameter int MAX_NODES   = 4096,
	parameter int MAX_PATTERN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mpcm_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mpcm_pkg::result_t result
);

	mpcm_pkg::dp_cmd_t    cmd;
	mpcm_pkg::dp_status_t st;

	// the controller accepts an item word only in its idle state
	mpcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.st         (st),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	// the result register sits in the datapath, so a waiting result does not hold
	// off the next item word; only its hand-off waits for the slot to drain
	mpcm_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_PATTERN (MAX_PATTERN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.result_stall (result_stall),
		.st           (st),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ rtl/core/mpcm_checker.sv @@
// Port-level checks for the matcher core, bound to the top level.
`timescale 1ns / 1ps
module mpcm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input mpcm_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input mpcm_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != mpcm_pkg::ST_OK |->
			result.match_length == '0 && !result.count_valid)
		else $error("error result carries match data");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.count_valid |-> result.uncovered_count == '0)
		else $error("uncovered count without count_valid");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.uncovered_count <= mpcm_pkg::COUNT_W'(mpcm_pkg::MAX_TEXT))
		else $error("uncovered count past saturation");

endmodule

bind multi_pattern_cover_matcher_core mpcm_checker u_mpcm_checker (.*);

@@ tb/tb.sv @@
// Testbench for the multi-pattern cover matcher: random stimulus and a checking scoreboard.
`timescale 1ns / 1ps
module tb;

	localparam int NODES      = 4096;
	localparam int PAT_MAX    = 64;
	localparam int WATCH_LIM  = 400000;  // watchdog limit, above the build of a full trie
	localparam int MODE_SPAN  = 300;     // words per idling mode
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Scoreboard: private copy of the automaton, plus the queue of expected result words.
	class cover_scoreboard;
		bit [11:0] child[NODES][mpcm_pkg::ALPHABET];
		bit [11:0] fail_of[NODES];
		bit [6:0]  depth_of[NODES];
		bit [6:0]  longest_of[NODES];
		bit        is_end[NODES];
		bit [11:0] order_q[NODES];
		int unsigned nodes, cursor, plen;
		bit [1:0]  perr;
		bit        scanning;
		int unsigned cur_state, fill, uncovered;
		bit [63:0] covered;
		mpcm_pkg::result_t expected_q[$];
		int        errors;

		function bit [63:0] ones_below(int unsigned n);
			if (n >= 64) return '1;
			return (64'd1 << n) - 64'd1;
		endfunction

		function int unsigned capped(int unsigned a, int unsigned b);
			return (a + b > mpcm_pkg::MAX_TEXT) ? mpcm_pkg::MAX_TEXT : a + b;
		endfunction

		function void build_links();
			int unsigned head, tail, now, f, u, fu;
			bit [6:0] own;
			head = 0;
			tail = 0;
			fail_of[0] = 0;
			longest_of[0] = 0;
			for (int c = 0; c < mpcm_pkg::ALPHABET; c++) begin
				u = child[0][c];
				if (u != 0) begin
					fail_of[u] = 0;
					longest_of[u] = is_end[u] ? depth_of[u] : 7'd0;
					order_q[tail++] = 12'(u);
				end
			end
			while (head < tail) begin
				now = order_q[head++];
				f = fail_of[now];
				for (int c = 0; c < mpcm_pkg::ALPHABET; c++) begin
					u = child[now][c];
					if (u == 0) begin
						child[now][c] = child[f][c];
					end else begin
						fu = child[f][c];
						own = is_end[u] ? depth_of[u] : 7'd0;
						fail_of[u] = 12'(fu);
						longest_of[u] = (own > longest_of[fu]) ? own : longest_of[fu];
						if (tail < NODES) order_q[tail++] = 12'(u);
					end
				end
			end
		endfunction

		function void clear_scan();
			cur_state = 0;
			covered = '0;
			fill = 0;
			uncovered = 0;
		endfunction

		// Note an accepted item word and queue the result it must produce.
		function void note_item(mpcm_pkg::item_t it);
			mpcm_pkg::result_t r;
			int unsigned nxt, m;
			r = '0;
			if (it.operation == mpcm_pkg::OP_PATTERN) begin
				if (scanning) begin
					r.status = mpcm_pkg::ST_BAD;
				end else begin
					if (perr == mpcm_pkg::ST_OK) begin
						if (plen >= PAT_MAX || it.symbol >= mpcm_pkg::ALPHABET) begin
							perr = mpcm_pkg::ST_BAD;
						end else begin
							nxt = child[cursor][it.symbol];
							if (nxt == 0) begin
								if (nodes + 1 >= NODES) begin
									perr = mpcm_pkg::ST_FULL;
								end else begin
									nodes++;
									nxt = nodes;
									depth_of[nxt] = depth_of[cursor] + 7'd1;
									child[cursor][it.symbol] = 12'(nxt);
								end
							end
							if (perr == mpcm_pkg::ST_OK) begin
								cursor = nxt;
								plen++;
							end
						end
					end
					r.status = perr;
					if (it.last) begin
						if (perr == mpcm_pkg::ST_OK) is_end[cursor] = 1'b1;
						cursor = 0;
						plen = 0;
						perr = mpcm_pkg::ST_OK;
					end
				end
			end else if (it.operation == mpcm_pkg::OP_BUILD) begin
				if (scanning) begin
					r.status = mpcm_pkg::ST_BAD;
				end else begin
					build_links();
					cursor = 0;
					plen = 0;
					perr = mpcm_pkg::ST_OK;
					scanning = 1'b1;
					clear_scan();
				end
			end else if (it.operation == mpcm_pkg::OP_TEXT) begin
				if (!scanning) begin
					r.status = mpcm_pkg::ST_BAD;
				end else begin
					cur_state = (it.symbol < mpcm_pkg::ALPHABET) ?
						child[cur_state][it.symbol] : 0;
					m = longest_of[cur_state];
					if (m > PAT_MAX) m = PAT_MAX;
					if (fill >= PAT_MAX) begin
						if (!covered[PAT_MAX-1]) uncovered = capped(uncovered, 1);
					end else begin
						fill++;
					end
					covered = (covered << 1) | ones_below(m);
					r.match_length = 7'(m);
					if (it.last) begin
						r.uncovered_count = 21'(capped(uncovered,
							$countones(~covered & ones_below(fill))));
						r.count_valid = 1'b1;
						clear_scan();
					end
				end
			end else begin
				r.status = mpcm_pkg::ST_BAD;
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(mpcm_pkg::result_t got);
			mpcm_pkg::result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.match_length !== exp_r.match_length) begin
				$display("%0t: match_length expected %0d actual %0d", $time,
					exp_r.match_length, got.match_length);
				errors++;
			end
			if (got.uncovered_count !== exp_r.uncovered_count) begin
				$display("%0t: uncovered_count expected %0d actual %0d", $time,
					exp_r.uncovered_count, got.uncovered_count);
				errors++;
			end
			if (got.count_valid !== exp_r.count_valid) begin
				$display("%0t: count_valid expected %0d actual %0d", $time,
					exp_r.count_valid, got.count_valid);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time,
					exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	mpcm_pkg::item_t   item;
	logic              result_valid;
	logic              result_stall;
	mpcm_pkg::result_t result;

	cover_scoreboard sb;
	int unsigned words_in;   // accepted item words; selects the idling mode
	int unsigned quiet;      // cycles since anything was accepted
	bit [7:0]    pat[$];

	multi_pattern_cover_matcher_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mode 0: sender idles 19%, receiver 61%; mode 1 the reverse; mode 2 no idling
	function int unsigned idle_mode();
		return (words_in / MODE_SPAN >= 2) ? 2 : words_in / MODE_SPAN;
	endfunction

	// Result side: check at the edge, then pick the stall for the next cycle.
	always @(posedge clk) begin
		int unsigned pct;
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
		pct = (idle_mode() == 0) ? 61 : (idle_mode() == 1) ? 19 : 0;
		result_stall <= ($urandom_range(99) < pct);
	end

	// Watchdog on any handshake. The long build pass is the worst quiet stretch.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCH_LIM) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Drive one item word and wait for its acceptance; valid stays high between words
	// unless an idle cycle is drawn, so it is never lowered and raised in one step.
	task automatic put_word(logic [1:0] op, logic [4:0] sym, logic lst);
		mpcm_pkg::item_t w;
		int unsigned pct;
		w.operation = op;
		w.symbol    = sym;
		w.last      = lst;
		pct = (idle_mode() == 0) ? 19 : (idle_mode() == 1) ? 61 : 0;
		while ($urandom_range(99) < pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		sb.note_item(w);
		words_in++;
	endtask

	task automatic put_pattern();
		for (int i = 0; i < pat.size(); i++)
			put_word(mpcm_pkg::OP_PATTERN, pat[i][4:0], i == pat.size() - 1);
	endtask

	// Mostly letters a..d so that texts hit the patterns; sometimes any letter.
	function bit [7:0] pick_letter();
		return ($urandom_range(99) < 80) ? 8'($urandom_range(3)) :
			8'($urandom_range(mpcm_pkg::ALPHABET - 1));
	endfunction

	initial begin
		int unsigned len;
		sb = new();
		words_in = 0;
		quiet = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wrong phase text, unused opcode, bad symbol mid pattern
		put_word(mpcm_pkg::OP_TEXT, 5'd0, 1'b0);
		put_word(OP_UNUSED, 5'd31, 1'b1);
		put_word(mpcm_pkg::OP_PATTERN, 5'd1, 1'b0);
		put_word(mpcm_pkg::OP_PATTERN, 5'd31, 1'b0);
		put_word(mpcm_pkg::OP_PATTERN, 5'd2, 1'b1);
		// single letter, duplicate and prefix patterns
		pat = '{8'd0};        put_pattern();
		pat = '{8'd0, 8'd1};  put_pattern();
		pat = '{8'd0, 8'd1};  put_pattern();
		pat = '{8'd25};       put_pattern();
		// longest legal pattern, then one symbol too many
		pat.delete();
		repeat (PAT_MAX) pat.push_back(8'd0);
		put_pattern();
		pat.delete();
		repeat (PAT_MAX + 1) pat.push_back(8'd24);
		put_pattern();

		// random short patterns, a few broken ones
		repeat (40) begin
			pat.delete();
			len = $urandom_range(1, 8);
			repeat (len) pat.push_back(($urandom_range(99) < 3) ?
				8'($urandom_range(26, 31)) : pick_letter());
			put_pattern();
		end

		put_word(mpcm_pkg::OP_BUILD, 5'($urandom_range(31)), 1'($urandom_range(1)));

		// scan phase: items of the load phase are now rejected
		put_word(mpcm_pkg::OP_BUILD, 5'd0, 1'b0);
		put_word(mpcm_pkg::OP_PATTERN, 5'd3, 1'b1);
		put_word(OP_UNUSED, 5'd0, 1'b0);
		// run of a's past the longest pattern, then a one-letter text
		for (int i = 0; i < 70; i++) put_word(mpcm_pkg::OP_TEXT, 5'd0, i == 69);
		put_word(mpcm_pkg::OP_TEXT, 5'd1, 1'b1);

		// random texts, mostly short, a few long, rare letters outside the alphabet
		repeat (15) begin
			len = ($urandom_range(99) < 10) ? $urandom_range(100, 200) : $urandom_range(1, 40);
			for (int i = 0; i < len; i++)
				put_word(mpcm_pkg::OP_TEXT, ($urandom_range(99) < 4) ?
					5'($urandom_range(26, 31)) : 5'(pick_letter()), i == len - 1);
		end

		@(posedge clk);
		item_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (PAT_MAX + 20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
